@@ sv/bpa_pkg.sv @@
// Shared constants for the bitmap page allocator: geometry, derived widths,
// status codes and the register map. No dependencies.
`default_nettype none
package bpa_pkg;

  localparam int unsigned NUM_PAGES    = 1024;
  localparam int unsigned PAGE_SIZE    = 4096;
  localparam int unsigned BITMAP_PAGES = 1;

  localparam int unsigned OCC_WORDS  = (NUM_PAGES + 31) / 32;
  localparam int unsigned WORD_AW    = (OCC_WORDS > 1) ? $clog2(OCC_WORDS) : 1;
  localparam int unsigned IDX_W      = $clog2(NUM_PAGES);
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam int unsigned LAST_BITS  = NUM_PAGES - 32 * (OCC_WORDS - 1);

  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(OCC_WORDS - 1);
  localparam logic [31:0] LAST_MASK =
      (LAST_BITS == 32) ? 32'hFFFF_FFFF : 32'((64'd1 << LAST_BITS) - 64'd1);

  localparam logic [31:0] PAGE_SIZE_W = 32'(PAGE_SIZE);
  localparam logic [31:0] FIRST_OFF   = 32'(64'(PAGE_SIZE) * 64'(BITMAP_PAGES));
  localparam logic [32:0] HEAP_SPAN   = 33'(64'(NUM_PAGES) * 64'(PAGE_SIZE));

  localparam int unsigned CFG_AW = 3;
  localparam logic REG_HEAP_BASE = 1'b0;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMEM    = 2'd1;
  localparam logic [1:0] ST_NOTALLOC = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

endpackage
`default_nettype wire

@@ sv/bitmap_page_allocator.sv @@
// Top level of the bitmap page allocator: command sequencer, bitmap RAM,
// free address decode and APB register. Depends on bpa_pkg, bpa_ram.
//
// A command is taken when start is high and busy is low; its result appears on
// status, page_index and page_address for one cycle with done high and cannot
// be held off. Allocate reads the bitmap RAM one word per cycle and stops at
// the first word with a free page, or at the last word when none is free.
// Free takes the page from the address offset with a shift, since the page
// size is a power of two, followed by a read-modify-write of one word; an
// address out of range skips the bitmap RAM. The bitmap reads as all free
// after reset through per-word valid bits; no clearing pass is needed.
// heap_base is written over APB at byte address 0 and must only change while
// the block is idle.
`default_nettype none
module bitmap_page_allocator (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      command,
  input  wire logic [31:0]               free_address,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [9:0]                     page_index,
  output logic [31:0]                    page_address,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [bpa_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    RANGE,
    FREE_RD,
    FREE_CHK,
    EMIT
  } state_t;

  state_t state;

  logic [31:0]                   heap_base;
  logic [bpa_pkg::OCC_WORDS-1:0] valid;
  logic [bpa_pkg::WORD_AW-1:0]   issue_addr;
  logic [bpa_pkg::WORD_AW-1:0]   chk_addr;
  logic                          chk_vld;
  logic [31:0]                   rem;
  logic [bpa_pkg::IDX_W-1:0]     quo;
  logic [1:0]                    res_status;
  logic [bpa_pkg::IDX_W-1:0]     res_idx;

  logic [31:0]                   ram_q;
  logic [31:0]                   word;
  logic [31:0]                   avail;
  logic                          found;
  logic [4:0]                    bitpos;
  logic                          we;
  logic [31:0]                   wdata;
  logic [31:0]                   off;
  logic [bpa_pkg::IDX_W:0]       page_num;
  logic [31:0]                   prod;
  logic                          free_hit;
  logic                          cfg_we;

  bpa_ram #(
    .WIDTH(32),
    .DEPTH(bpa_pkg::OCC_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(chk_addr),
    .wdata(wdata),
    .raddr(issue_addr),
    .rdata(ram_q)
  );

  assign busy   = (state != IDLE);
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == bpa_pkg::REG_HEAP_BASE) ? heap_base : 32'd0;

  assign word  = valid[chk_addr] ? ram_q : 32'd0;
  assign avail = ~word & ((chk_addr == bpa_pkg::LAST_WORD) ? bpa_pkg::LAST_MASK
                                                            : 32'hFFFF_FFFF);
  assign found = |avail;

  always_comb begin
    bitpos = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (avail[i]) begin
        bitpos = 5'(i);
      end
    end
  end

  assign free_hit = word[quo[4:0]];

  always_comb begin
    we    = 1'b0;
    wdata = word | (32'd1 << bitpos);
    if (state == SCAN && chk_vld && found) begin
      we = 1'b1;
    end else if (state == FREE_CHK && free_hit) begin
      we    = 1'b1;
      wdata = word & ~(32'd1 << quo[4:0]);
    end
  end

  assign off = free_address - heap_base - bpa_pkg::FIRST_OFF;

  assign page_num = {1'b0, res_idx} + (bpa_pkg::IDX_W + 1)'(bpa_pkg::BITMAP_PAGES);
  assign prod     = bpa_pkg::PAGE_SIZE_W * 32'(page_num);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      done      <= 1'b0;
      heap_base <= 32'd0;
      valid     <= '0;
      chk_vld   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we && paddr[2] == bpa_pkg::REG_HEAP_BASE) begin
        heap_base <= pwdata;
      end
      if (we) begin
        valid[chk_addr] <= 1'b1;
      end
      case (state)
        IDLE: begin
          if (start) begin
            if (command) begin
              rem   <= off;
              state <= RANGE;
            end else begin
              issue_addr <= '0;
              chk_vld    <= 1'b0;
              state      <= SCAN;
            end
          end
        end
        SCAN: begin
          if (chk_vld && found) begin
            res_status <= bpa_pkg::ST_OK;
            res_idx    <= bpa_pkg::IDX_W'({chk_addr, bitpos});
            state      <= EMIT;
          end else if (chk_vld && chk_addr == bpa_pkg::LAST_WORD) begin
            res_status <= bpa_pkg::ST_NOMEM;
            res_idx    <= '0;
            state      <= EMIT;
          end else begin
            chk_addr <= issue_addr;
            chk_vld  <= 1'b1;
            if (issue_addr != bpa_pkg::LAST_WORD) begin
              issue_addr <= issue_addr + 1'b1;
            end
          end
        end
        RANGE: begin
          if ({1'b0, rem} >= bpa_pkg::HEAP_SPAN) begin
            res_status <= bpa_pkg::ST_RANGE;
            res_idx    <= '0;
            state      <= EMIT;
          end else begin
            quo        <= rem[bpa_pkg::PAGE_SHIFT +: bpa_pkg::IDX_W];
            issue_addr <= rem[bpa_pkg::PAGE_SHIFT + 5 +: bpa_pkg::WORD_AW];
            chk_addr   <= rem[bpa_pkg::PAGE_SHIFT + 5 +: bpa_pkg::WORD_AW];
            state      <= FREE_RD;
          end
        end
        FREE_RD: begin
          state <= FREE_CHK;
        end
        FREE_CHK: begin
          res_status <= free_hit ? bpa_pkg::ST_OK : bpa_pkg::ST_NOTALLOC;
          res_idx    <= quo;
          state      <= EMIT;
        end
        EMIT: begin
          status       <= res_status;
          page_index   <= 10'(res_idx);
          page_address <= (res_status == bpa_pkg::ST_OK ||
                           res_status == bpa_pkg::ST_NOTALLOC) ? (heap_base + prod)
                                                               : 32'd0;
          done         <= 1'b1;
          state        <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/bpa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module bpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
